// ===== design/sact_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sact_pkg: shared definitions for the set-associative cache tag lookup
// Types, constants and the replacement LFSR step used by the block files.
// ----------------------------------------------------------------------------
package sact_pkg;

  localparam int DEF_MAX_BLOCKS = 2048;
  localparam int DEF_ADDR_WIDTH = 32;
  localparam int TAG_W          = 28;
  localparam int WAY_OUT_W      = 11;
  localparam int APB_ADDR_W     = 4;
  localparam int APB_DATA_W     = 32;

  // Register indexes (byte address is four times the index).
  localparam logic [1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [1:0] REG_BLOCK_BITS  = 2'd1;
  localparam logic [1:0] REG_WAY_BITS    = 2'd2;
  localparam logic [1:0] REG_SEED        = 2'd3;

  // Register reset values.
  localparam logic [2:0]  RST_OFFSET_BITS = 3'd4;
  localparam logic [3:0]  RST_BLOCK_BITS  = 4'd11;
  localparam logic [3:0]  RST_WAY_BITS    = 4'd3;
  localparam logic [15:0] RST_SEED        = 16'd44257;

  typedef struct packed {
    logic [2:0]  offset_bits;
    logic [3:0]  block_bits;
    logic [3:0]  way_bits;
    logic        seed_load;
    logic [15:0] seed;
  } cfg_t;

  typedef struct packed {
    logic                 valid;
    logic                 hit;
    logic [WAY_OUT_W-1:0] way;
    logic [31:0]          hit_count;
    logic [31:0]          miss_count;
  } res_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CLEAR  = 5'b00010,
    ST_SETUP  = 5'b00100,
    ST_SEARCH = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  // Fibonacci LFSR, taps x^16 + x^14 + x^13 + x^11 + 1, shifting right.
  function automatic logic [15:0] lfsr_next(input logic [15:0] v);
    logic fb;
    fb = v[0] ^ v[2] ^ v[3] ^ v[5];
    return {fb, v[15:1]};
  endfunction

endpackage

// ===== design/sact_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sact_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sact_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/sact_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sact_cfg: configuration register file
// APB-style register access for the geometry and the replacement seed.
// ----------------------------------------------------------------------------
module sact_cfg
  import sact_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [2:0]  offset_bits;
  logic [3:0]  block_bits;
  logic [3:0]  way_bits;
  logic [15:0] random_seed;
  logic        seed_load;
  logic        wr;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr      = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= RST_OFFSET_BITS;
      block_bits  <= RST_BLOCK_BITS;
      way_bits    <= RST_WAY_BITS;
      random_seed <= RST_SEED;
      seed_load   <= 1'b0;
    end else begin
      seed_load <= 1'b0;
      if (wr) begin
        case (reg_idx)
          REG_OFFSET_BITS: offset_bits <= pwdata[2:0];
          REG_BLOCK_BITS:  block_bits  <= pwdata[3:0];
          REG_WAY_BITS:    way_bits    <= pwdata[3:0];
          REG_SEED: begin
            random_seed <= pwdata[15:0];
            seed_load   <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (reg_idx)
      REG_OFFSET_BITS: prdata = {29'd0, offset_bits};
      REG_BLOCK_BITS:  prdata = {28'd0, block_bits};
      REG_WAY_BITS:    prdata = {28'd0, way_bits};
      REG_SEED:        prdata = {16'd0, random_seed};
      default:         prdata = '0;
    endcase
  end

  // The seed register loads the LFSR in the cycle after the write; no lookup
  // observes the gap if the user writes it while idle, which is not enforced.
  assign cfg.offset_bits = offset_bits;
  assign cfg.block_bits  = block_bits;
  assign cfg.way_bits    = way_bits;
  assign cfg.seed_load   = seed_load;
  assign cfg.seed        = random_seed;

endmodule

// ===== design/sact_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sact_ctrl: lookup sequencer
// Walks the ways of one set through a single tag comparator, fills or
// replaces on a miss and keeps the hit and miss counters.
// ----------------------------------------------------------------------------
module sact_ctrl
  import sact_pkg::*;
#(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
  parameter int ADDR_WIDTH = DEF_ADDR_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  req_valid,
  input  logic [ADDR_WIDTH-1:0] address,
  output logic                  busy,
  input  logic                  out_free,
  output res_t                  res
);

  localparam int MBB   = $clog2(MAX_BLOCKS + 1) - 1;
  localparam int IDX_W = MBB;
  localparam int DEPTH = 1 << MBB;
  localparam int ENT_W = TAG_W + 1;

  state_t state, state_next;

  logic [IDX_W-1:0]      clr_idx;
  logic [ADDR_WIDTH-1:0] addr_q;
  logic [TAG_W-1:0]      tag_q;
  logic [IDX_W-1:0]      base_q;
  logic [IDX_W-1:0]      mask_q;
  logic [IDX_W-1:0]      iss_way;
  logic                  iss_done;
  logic                  cmp_pend;
  logic [IDX_W-1:0]      cmp_way;
  logic                  inv_found;
  logic [IDX_W-1:0]      inv_way;
  logic                  res_hit;
  logic [IDX_W-1:0]      res_way;
  logic [31:0]           hit_counter;
  logic [31:0]           miss_counter;
  logic [15:0]           lfsr;

  // Geometry decode for the setup cycle.
  logic [3:0]            bb, wb, sb;
  logic [4:0]            tag_sh;
  logic [ADDR_WIDTH-1:0] off_shift, tag_shift;
  logic [IDX_W:0]        set_one, way_one;
  logic [IDX_W-1:0]      set_mask, way_mask, set_idx, set_base;

  // Compare and fill decisions.
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr, ram_raddr;
  logic [ENT_W-1:0]      ram_wdata, ram_rdata;
  logic                  rd_valid, match, last;
  logic [15:0]           lfsr_step;
  logic [IDX_W-1:0]      victim, fill_way;
  logic                  use_lfsr;

  always_comb begin
    bb = (5'(cfg.block_bits) > 5'(MBB)) ? 4'(MBB) : cfg.block_bits;
    wb = (cfg.way_bits > bb) ? bb : cfg.way_bits;
    sb = bb - wb;
    tag_sh    = 5'(cfg.offset_bits) + 5'(sb);
    off_shift = addr_q >> cfg.offset_bits;
    tag_shift = addr_q >> tag_sh;
    set_one   = (IDX_W+1)'(1) << sb;
    way_one   = (IDX_W+1)'(1) << wb;
    set_mask  = IDX_W'(set_one - (IDX_W+1)'(1));
    way_mask  = IDX_W'(way_one - (IDX_W+1)'(1));
    set_idx   = IDX_W'(off_shift) & set_mask;
    set_base  = set_idx << wb;
  end

  assign rd_valid  = ram_rdata[TAG_W];
  assign match     = cmp_pend && rd_valid && (ram_rdata[TAG_W-1:0] == tag_q);
  assign last      = cmp_pend && (cmp_way == mask_q);
  assign lfsr_step = lfsr_next(lfsr);
  assign victim    = IDX_W'(lfsr_step) & mask_q;
  assign use_lfsr  = !inv_found && rd_valid;

  always_comb begin
    if (inv_found) begin
      fill_way = inv_way;
    end else if (!rd_valid) begin
      fill_way = cmp_way;
    end else begin
      fill_way = victim;
    end
  end

  always_comb begin
    ram_raddr = base_q | iss_way;
    ram_we    = 1'b0;
    ram_waddr = base_q | fill_way;
    ram_wdata = {1'b1, tag_q};
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx;
      ram_wdata = '0;
    end else if (state == ST_SEARCH && last && !match) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (clr_idx == {IDX_W{1'b1}}) state_next = ST_IDLE;
      ST_IDLE:   if (req_valid) state_next = ST_SETUP;
      ST_SETUP:  state_next = ST_SEARCH;
      ST_SEARCH: if (match || last) state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_idx      <= '0;
      iss_done     <= 1'b0;
      cmp_pend     <= 1'b0;
      inv_found    <= 1'b0;
      hit_counter  <= '0;
      miss_counter <= '0;
      lfsr         <= RST_SEED;
    end else begin
      state <= state_next;
      if (cfg.seed_load) begin
        lfsr <= cfg.seed;
      end
      case (state)
        ST_CLEAR: clr_idx <= clr_idx + 1'b1;
        ST_IDLE: begin
          if (req_valid) begin
            addr_q <= address;
          end
        end
        ST_SETUP: begin
          tag_q     <= TAG_W'(tag_shift);
          base_q    <= set_base;
          mask_q    <= way_mask;
          iss_way   <= '0;
          iss_done  <= 1'b0;
          cmp_pend  <= 1'b0;
          inv_found <= 1'b0;
        end
        ST_SEARCH: begin
          // Reads run one way ahead of the comparator.
          if (!iss_done) begin
            iss_way <= iss_way + 1'b1;
            if (iss_way == mask_q) begin
              iss_done <= 1'b1;
            end
          end
          // The pipeline empties once the last way is issued or a way hits.
          cmp_pend <= !iss_done && !match;
          cmp_way  <= iss_way;
          if (match) begin
            res_hit     <= 1'b1;
            res_way     <= cmp_way;
            hit_counter <= hit_counter + 1'b1;
          end else if (last) begin
            res_hit      <= 1'b0;
            res_way      <= fill_way;
            miss_counter <= miss_counter + 1'b1;
            if (use_lfsr && !cfg.seed_load) begin
              lfsr <= lfsr_step;
            end
          end else if (cmp_pend && !rd_valid && !inv_found) begin
            inv_found <= 1'b1;
            inv_way   <= cmp_way;
          end
        end
        default: ;
      endcase
    end
  end

  sact_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy           = (state != ST_IDLE);
  assign res.valid      = (state == ST_FINISH);
  assign res.hit        = res_hit;
  assign res.way        = WAY_OUT_W'(res_way);
  assign res.hit_count  = hit_counter;
  assign res.miss_count = miss_counter;

`ifndef SYNTHESIS
  // The tag store is written only by the clearing pass or at a miss decision.
  a_write_states: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_CLEAR || (state == ST_SEARCH && last && !match)))
    else $error("tag store written outside clear or miss resolution");

  // Every finished lookup moves exactly one of the two counters by one.
  a_one_count: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(state) == ST_SEARCH && state == ST_FINISH) |->
      (32'(hit_counter + miss_counter) ==
       32'($past(hit_counter) + $past(miss_counter) + 32'd1)))
    else $error("lookup did not advance exactly one counter");

  // The clearing pass only ever hands over to idle.
  a_clear_exit: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(state) == ST_CLEAR && state != ST_CLEAR) |->
      state == ST_IDLE)
    else $error("clearing pass left to a state other than idle");

  // A compare is pending only while the set is being walked.
  a_cmp_in_search: assert property (@(posedge clk) disable iff (rst)
    cmp_pend |-> state == ST_SEARCH)
    else $error("comparison pending outside the search");
`endif

endmodule

// ===== design/set_assoc_cache_tag_lookup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lookup: set-associative cache tag lookup
// Tag and valid store with random replacement, hit and miss counters.
// ----------------------------------------------------------------------------
// Usage:
// The request channel (req_valid, req_stall, address) takes one byte address
// per transaction. The response channel (rsp_valid, rsp_stall, hit, way_used,
// hit_count, miss_count) returns exactly one transaction per request.
// Geometry and the LFSR seed are set through the APB-style port while idle;
// writing the seed reloads the replacement LFSR.
// Timing: the ways of the addressed set go one per cycle through a single
// tag comparator reading a one-port-read tag RAM. A request walks N ways
// before deciding: a hit at way k walks k + 1, a miss walks all ways of the
// set after saturation, up to 2048 with the default MAX_BLOCKS when fully
// associative. A request passes setup, search and finish, where it loads
// the output register; only back in idle is the next request accepted.
// Reset: rst is synchronous. After it, a clearing pass writes every tag RAM
// entry invalid, one entry per cycle (2^floor(log2(MAX_BLOCKS)) entries,
// 2048 by default), with req_stall high; configuration writes still work.
// Stall: the result sits in an output register. While rsp_stall holds it,
// the next request is accepted and searched, and waits to finish until the
// register is free.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_lookup
  import sact_pkg::*;
#(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
  parameter int ADDR_WIDTH = DEF_ADDR_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // Request channel
  input  logic                  req_valid,
  output logic                  req_stall,
  input  logic [ADDR_WIDTH-1:0] address,
  // Response channel
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output logic                  hit,
  output logic [WAY_OUT_W-1:0]  way_used,
  output logic [31:0]           hit_count,
  output logic [31:0]           miss_count
);

  cfg_t cfg;
  res_t res;
  logic busy;
  logic out_free;

  sact_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sact_ctrl #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_valid (req_valid),
    .address   (address),
    .busy      (busy),
    .out_free  (out_free),
    .res       (res)
  );

  // The sequencer only takes a request when it is idle.
  assign req_stall = busy;

  // The output register is free when empty or when its transaction is being
  // taken in this cycle.
  assign out_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_free) begin
      rsp_valid <= res.valid;
    end
  end

  // Payload holds while stalled; no reset needed.
  always_ff @(posedge clk) begin
    if (out_free && res.valid) begin
      hit        <= res.hit;
      way_used   <= res.way;
      hit_count  <= res.hit_count;
      miss_count <= res.miss_count;
    end
  end

endmodule

// ===== verif/tag_lookup_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tag_lookup_checker: scoreboard for the set-associative cache tag lookup
// Follows register writes and requests, predicts each response and compares.
// ----------------------------------------------------------------------------
module tag_lookup_checker
  import sact_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic                  req_valid,
  input  logic                  req_stall,
  input  logic [31:0]           address,
  input  logic                  rsp_valid,
  input  logic                  rsp_stall,
  input  logic                  hit,
  input  logic [WAY_OUT_W-1:0]  way_used,
  input  logic [31:0]           hit_count,
  input  logic [31:0]           miss_count,
  output int                    error_count,
  output int                    results_seen
);

  localparam int LINES    = DEF_MAX_BLOCKS;
  localparam int IDX_BITS = $clog2(DEF_MAX_BLOCKS);

  typedef struct packed {
    logic                 hit;
    logic [WAY_OUT_W-1:0] way;
    logic [31:0]          hits;
    logic [31:0]          misses;
  } lookup_t;

  logic [2:0]  off_bits;
  logic [3:0]  blk_bits;
  logic [3:0]  way_bits;
  logic [15:0] victim_lfsr;
  logic [31:0] hits_total;
  logic [31:0] misses_total;
  logic        line_valid [LINES];
  logic [TAG_W-1:0] line_tag [LINES];
  lookup_t     lookup_q [$];

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    error_count++;
    if (error_count <= 50) begin
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
    end
  endtask

  // Searches the addressed set and updates the tag store exactly as one
  // lookup does; returns the response this transaction must produce.
  function automatic lookup_t predict_lookup(input logic [31:0] a);
    int          bb;
    int          wb;
    int          sb;
    int          nways;
    int          base;
    int          w;
    logic [31:0] set_idx;
    logic [31:0] shifted;
    logic [TAG_W-1:0] tag;
    logic        found;
    logic        placed;
    logic        fb;
    lookup_t     r;
    bb = (blk_bits > IDX_BITS) ? IDX_BITS : int'(blk_bits);
    wb = (way_bits > bb) ? bb : int'(way_bits);
    sb = bb - wb;
    nways = 1 << wb;
    set_idx = (a >> off_bits) & ((32'd1 << sb) - 32'd1);
    shifted = a >> (off_bits + sb);
    tag = shifted[TAG_W-1:0];
    base = int'(set_idx) << wb;
    found = 1'b0;
    placed = 1'b0;
    r = '0;
    for (w = 0; w < nways && !found; w++) begin
      if (line_valid[base + w] && line_tag[base + w] == tag) begin
        found = 1'b1;
        r.way = WAY_OUT_W'(w);
      end
    end
    if (found) begin
      hits_total++;
    end else begin
      misses_total++;
      for (w = 0; w < nways && !placed; w++) begin
        if (!line_valid[base + w]) begin
          line_valid[base + w] = 1'b1;
          line_tag[base + w] = tag;
          r.way = WAY_OUT_W'(w);
          placed = 1'b1;
        end
      end
      if (!placed) begin
        fb = victim_lfsr[0] ^ victim_lfsr[2] ^ victim_lfsr[3] ^ victim_lfsr[5];
        victim_lfsr = {fb, victim_lfsr[15:1]};
        w = int'(victim_lfsr) & (nways - 1);
        line_valid[base + w] = 1'b1;
        line_tag[base + w] = tag;
        r.way = WAY_OUT_W'(w);
      end
    end
    r.hit = found;
    r.hits = hits_total;
    r.misses = misses_total;
    return r;
  endfunction

  initial begin
    error_count = 0;
    results_seen = 0;
  end

  always @(posedge clk) begin
    lookup_t want;
    if (rst) begin
      off_bits = RST_OFFSET_BITS;
      blk_bits = RST_BLOCK_BITS;
      way_bits = RST_WAY_BITS;
      victim_lfsr = RST_SEED;
      hits_total = '0;
      misses_total = '0;
      for (int i = 0; i < LINES; i++) begin
        line_valid[i] = 1'b0;
        line_tag[i] = '0;
      end
      lookup_q.delete();
      results_seen <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_OFFSET_BITS: off_bits = pwdata[2:0];
          REG_BLOCK_BITS:  blk_bits = pwdata[3:0];
          REG_WAY_BITS:    way_bits = pwdata[3:0];
          REG_SEED:        victim_lfsr = pwdata[15:0];
          default: ;
        endcase
      end
      if (req_valid && !req_stall) begin
        lookup_q.push_back(predict_lookup(address));
      end
      if (rsp_valid && !rsp_stall) begin
        results_seen <= results_seen + 1;
        if (lookup_q.size() == 0) begin
          report_mismatch("unrequested response", '0, {31'd0, hit});
        end else begin
          want = lookup_q.pop_front();
          if (hit !== want.hit) report_mismatch("hit", {31'd0, want.hit}, {31'd0, hit});
          if (way_used !== want.way) begin
            report_mismatch("way_used", {21'd0, want.way}, {21'd0, way_used});
          end
          if (hit_count !== want.hits) report_mismatch("hit_count", want.hits, hit_count);
          if (miss_count !== want.misses) begin
            report_mismatch("miss_count", want.misses, miss_count);
          end
        end
      end
    end
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression for the set-associative cache tag lookup
// Drives address lookups and register writes; a checker predicts responses.
// ----------------------------------------------------------------------------
// The run starts with hand-picked lookups under the reset geometry (address
// extremes, repeated hits, one set filled past its capacity so that random
// replacement kicks in), then walks through a series of geometries: fully
// associative, a single block with tag aliasing, small sets with a zero seed,
// saturated way counts, two blocks, direct mapped and a final hold-off run.
// Each geometry gets a batch of random addresses drawn mostly from a small
// working set so that hits, fills and replacements all happen often.
// Registers are only written once every outstanding response has come back.
// ----------------------------------------------------------------------------
module tb;
  import sact_pkg::*;

  localparam int HOLD_CYCLES = 64;
  localparam int IDX_BITS    = $clog2(DEF_MAX_BLOCKS);

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  req_valid;
  logic                  req_stall;
  logic [31:0]           address;
  logic                  rsp_valid;
  logic                  rsp_stall;
  logic                  hit;
  logic [WAY_OUT_W-1:0]  way_used;
  logic [31:0]           hit_count;
  logic [31:0]           miss_count;

  int error_count;
  int results_seen;
  int lookups_sent;

  // Random idling on both channels is enabled while this is set.
  bit idle_on;
  // Each increment asks the response side for one long hold-off.
  int hold_asks;

  // Effective geometry, after saturation, for shaping random addresses.
  int cur_off;
  int cur_sb;
  int cur_wb;
  logic [31:0] recent_addrs [$];

  set_assoc_cache_tag_lookup dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .address    (address),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .hit        (hit),
    .way_used   (way_used),
    .hit_count  (hit_count),
    .miss_count (miss_count)
  );

  tag_lookup_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .address      (address),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .hit          (hit),
    .way_used     (way_used),
    .hit_count    (hit_count),
    .miss_count   (miss_count),
    .error_count  (error_count),
    .results_seen (results_seen)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Setup phase, then access phase; the register takes the value at the
  // access edge. The bus then goes idle so back-to-back writes stay clean.
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Writes all four registers and records the saturated geometry that the
  // block will actually use.
  task automatic set_geometry(input int off, input int bb, input int wb,
                              input logic [15:0] seed);
    int bb_eff;
    reg_write(REG_OFFSET_BITS, 32'(off));
    reg_write(REG_BLOCK_BITS, 32'(bb));
    reg_write(REG_WAY_BITS, 32'(wb));
    reg_write(REG_SEED, {16'd0, seed});
    bb_eff = (bb > IDX_BITS) ? IDX_BITS : bb;
    cur_wb = (wb > bb_eff) ? bb_eff : wb;
    cur_sb = bb_eff - cur_wb;
    cur_off = off;
  endtask

  // Offers one lookup, possibly after a short idle burst, and returns at the
  // edge where the transaction is accepted.
  task automatic send_lookup(input logic [31:0] a);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_valid <= 1'b1;
    address <= a;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    lookups_sent++;
  endtask

  // Waits until every accepted lookup has produced its response.
  task automatic drain();
    req_valid <= 1'b0;
    while (results_seen != lookups_sent) @(posedge clk);
  endtask

  // Mostly addresses from a small working set: three more tags than there are
  // ways in up to four sets, plus reuse of recent addresses. The rest are fully
  // random so every address bit toggles.
  function automatic logic [31:0] pick_addr();
    logic [31:0] a;
    logic [31:0] part;
    if (recent_addrs.size() > 0 && $urandom_range(0, 2) == 0) begin
      return recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
    end
    if ($urandom_range(0, 7) == 0) begin
      a = $urandom;
    end else begin
      a = $urandom_range(0, (1 << cur_wb) + 2);
      a = a << (cur_off + cur_sb);
      part = $urandom_range(0, 3);
      a = a | ((part & ((32'd1 << cur_sb) - 32'd1)) << cur_off);
      part = $urandom;
      a = a | (part & ((32'd1 << cur_off) - 32'd1));
    end
    recent_addrs.push_back(a);
    if (recent_addrs.size() > 24) void'(recent_addrs.pop_front());
    return a;
  endfunction

  // Random lookups; idling stops from item quiet_from on.
  task automatic random_lookups(input int count, input int quiet_from);
    for (int i = 0; i < count; i++) begin
      if (i == quiet_from) idle_on = 1'b0;
      send_lookup(pick_addr());
    end
    drain();
  endtask

  // Response side: random stall bursts, and on request one long hold-off
  // during which the block must fill up and push back on its input.
  initial begin
    int burst_left;
    int hold_left;
    int holds_served;
    burst_left = 0;
    hold_left = 0;
    holds_served = 0;
    rsp_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_asks && hold_left == 0) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        burst_left = $urandom_range(0, 2);
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_valid = 1'b0;
    address = '0;
    idle_on = 1'b1;
    hold_asks = 0;
    lookups_sent = 0;
    // Reset geometry: 16-byte lines, 2048 blocks, 8 ways, 256 sets.
    cur_off = RST_OFFSET_BITS;
    cur_wb = RST_WAY_BITS;
    cur_sb = RST_BLOCK_BITS - RST_WAY_BITS;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Address extremes, then the same lines again, which must hit. The block
    // is still clearing its tag store, so the first acceptance waits for it.
    send_lookup(32'h0000_0000);
    send_lookup(32'hFFFF_FFFF);
    send_lookup(32'h0000_000F);
    send_lookup(32'hFFFF_FFF0);
    // Ten more tags into set 0: seven fill the free ways, the last three
    // overflow the set and take victims picked by the LFSR.
    for (int t = 1; t <= 10; t++) send_lookup(32'(t) << 12);
    send_lookup(32'h0000_1008);
    send_lookup(32'h0000_7004);
    drain();

    // Fully associative over all 2048 blocks, reached by saturating both
    // block and way counts; every miss walks the whole cache, so keep it short.
    set_geometry(7, 15, 15, 16'h0001);
    random_lookups(8, 8);

    // A single block with no line offset: the tag is the low 28 address bits,
    // so addresses differing only in the top nibble alias onto one line.
    set_geometry(0, 0, 0, 16'hFFFF);
    send_lookup(32'h0000_00A5);
    send_lookup(32'hF000_00A5);
    send_lookup(32'h1000_00A5);
    random_lookups(27, 27);

    // Four sets of four ways with a zero seed: the LFSR is stuck at zero and
    // every replacement must land on way 0.
    set_geometry(4, 4, 2, 16'h0000);
    random_lookups(40, 40);

    // More ways than blocks: the way count saturates and 64 blocks become
    // one fully associative set.
    set_geometry(5, 6, 9, 16'($urandom_range(1, 65535)));
    random_lookups(40, 40);

    // A stretch with no idling at all: two blocks, fully associative.
    idle_on = 1'b0;
    set_geometry(3, 1, 1, 16'hACE1);
    random_lookups(30, 30);
    idle_on = 1'b1;

    // Direct mapped over 2048 sets; the small working set forces conflicts.
    set_geometry(6, 11, 0, 16'($urandom_range(1, 65535)));
    random_lookups(40, 40);

    // Final phase: a long response hold-off right away so the request side
    // backs up, then the tail of the run without any idling.
    set_geometry(4, 5, 3, 16'($urandom_range(1, 65535)));
    hold_asks++;
    random_lookups(80, 40);

    // Allow for a stray late response before the verdict.
    repeat (64) @(posedge clk);
    if (error_count == 0) begin
      $display("set_assoc_cache_tag_lookup regression: pass");
    end else begin
      $display("set_assoc_cache_tag_lookup regression: fail");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run of this stimulus.
  initial begin
    #1000000;
    $display("set_assoc_cache_tag_lookup regression: fail");
    $finish;
  end

endmodule
